FILE: hdl/ctap_pkg.sv
package ctap_pkg;

	// packet geometry
	localparam int PACKET_BYTES = 64;
	localparam int POS_W        = $clog2(PACKET_BYTES);

	localparam logic [POS_W-1:0] POS_TYPE       = POS_W'(4);
	localparam logic [POS_W-1:0] POS_LEN_HI     = POS_W'(5);
	localparam logic [POS_W-1:0] POS_LEN_LO     = POS_W'(6);
	localparam logic [POS_W-1:0] POS_INIT_DATA  = POS_W'(7);
	localparam logic [POS_W-1:0] POS_CONT_DATA  = POS_W'(5);
	localparam logic [POS_W-1:0] POS_LAST       = POS_W'(PACKET_BYTES - 1);

	localparam int INIT_FLAG_BIT = 7;

	localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd7609;

	// result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	// packet status codes
	localparam logic [1:0] STATUS_IN_PROGRESS = 2'd0;
	localparam logic [1:0] STATUS_COMPLETE    = 2'd1;
	localparam logic [1:0] STATUS_REFUSED     = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_BUSY     = 2'd1;
	localparam logic [1:0] ERR_LENGTH   = 2'd2;
	localparam logic [1:0] ERR_SEQUENCE = 2'd3;

	// output queue
	localparam int RESQ_DEPTH = 4;
	localparam int RESQ_AW    = $clog2(RESQ_DEPTH);
	localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  error;
		logic [31:0] channel;
		logic [6:0]  command;
		logic [15:0] length;
	} outcome_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		logic [15:0] payload_offset;
		logic [1:0]  packet_status;
		logic [1:0]  error_code;
		logic [31:0] channel_id;
		logic [6:0]  command;
		logic [15:0] message_length;
		logic        last_result;
	} result_t;

endpackage

FILE: hdl/ctap_report_if.sv
interface ctap_report_if;
	logic       valid;
	logic       ready;
	logic [7:0] report_byte;
	logic       start_of_packet;

	modport source (output valid, output report_byte, output start_of_packet, input ready);
	modport sink (input valid, input report_byte, input start_of_packet, output ready);
endinterface

FILE: hdl/ctap_result_if.sv
interface ctap_result_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  payload_byte;
	logic [15:0] payload_offset;
	logic [1:0]  packet_status;
	logic [1:0]  error_code;
	logic [31:0] channel_id;
	logic [6:0]  command;
	logic [15:0] message_length;
	logic        last_result;

	modport source (
		output valid, output result_kind, output payload_byte, output payload_offset,
		output packet_status, output error_code, output channel_id, output command,
		output message_length, output last_result, input ready
	);
	modport sink (
		input valid, input result_kind, input payload_byte, input payload_offset,
		input packet_status, input error_code, input channel_id, input command,
		input message_length, input last_result, output ready
	);
endinterface

FILE: hdl/ctap_hid_message_reassembler_core.sv
// channel   direction  word                                   handshake
// report    in         report_byte, start_of_packet           valid/ready
// result    out        one result (payload byte or status)    valid/ready
// cfg       in         max_payload                            cfg_wr_en, no wait
//
// one report word is taken per cycle; its zero, one or two results are
// written into a four-entry result queue at that edge and offered from
// the next cycle on, one per cycle while result.ready is high
// report.ready stays high while the queue has room for two results, so
// the input stalls only when the result side holds back
// arst_n clears packet, transaction and queue state; max_payload goes to 7609
module ctap_hid_message_reassembler_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [15:0]          cfg_wr_data,
	ctap_report_if.sink          report,
	ctap_result_if.source        result
);

	// configuration
	logic [15:0] max_payload_q;

	// packet parsing state
	logic [ctap_pkg::POS_W-1:0] pos_q, pos_d;
	logic [31:0] hdr_chan_q, hdr_chan_d;
	logic [7:0]  hdr_type_q, hdr_type_d;
	logic [7:0]  hdr_len_hi_q, hdr_len_hi_d;
	logic        accepting_q, accepting_d;
	ctap_pkg::outcome_t outcome_q, outcome_d;

	// open transaction
	logic [31:0] open_chan_q, open_chan_d;
	logic [6:0]  open_cmd_q, open_cmd_d;
	logic [15:0] exp_len_q, exp_len_d;
	logic [15:0] rcv_cnt_q, rcv_cnt_d;
	logic [7:0]  next_seq_q, next_seq_d;

	// result queue
	ctap_pkg::result_t resq_q [ctap_pkg::RESQ_DEPTH];
	logic [ctap_pkg::RESQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [ctap_pkg::RESQ_CW-1:0] cnt_q;

	// per-word decode
	logic [ctap_pkg::POS_W-1:0] pos;
	logic [ctap_pkg::POS_W-1:0] data_start;
	logic [15:0] init_len;
	logic        do_complete;
	logic        have_pay, have_stat;
	ctap_pkg::result_t pay_res, stat_res, res0, res1;
	logic [1:0]  n_res;
	logic        in_acc, out_acc;
	logic [ctap_pkg::RESQ_AW-1:0] wr_ptr_p1;

	assign in_acc  = report.valid && report.ready;
	assign out_acc = result.valid && result.ready;

	always_comb begin
		pos          = report.start_of_packet ? '0 : pos_q;
		pos_d        = pos_q;
		hdr_chan_d   = hdr_chan_q;
		hdr_type_d   = hdr_type_q;
		hdr_len_hi_d = hdr_len_hi_q;
		accepting_d  = accepting_q;
		outcome_d    = outcome_q;
		open_chan_d  = open_chan_q;
		open_cmd_d   = open_cmd_q;
		exp_len_d    = exp_len_q;
		rcv_cnt_d    = rcv_cnt_q;
		next_seq_d   = next_seq_q;
		do_complete  = 1'b0;
		have_pay     = 1'b0;
		have_stat    = 1'b0;
		init_len     = {hdr_len_hi_q, report.report_byte};
		pay_res      = '0;
		stat_res     = '0;

		// first word of a packet wipes the per-packet state
		if (pos == '0) begin
			outcome_d    = '0;
			accepting_d  = 1'b0;
			hdr_type_d   = '0;
			hdr_len_hi_d = '0;
		end

		if (pos < ctap_pkg::POS_TYPE) begin
			hdr_chan_d = {hdr_chan_q[23:0], report.report_byte};
		end else if (pos == ctap_pkg::POS_TYPE) begin
			hdr_type_d = report.report_byte;
			// continuation checks
			if (!report.report_byte[ctap_pkg::INIT_FLAG_BIT]) begin
				if (open_cmd_q == '0) begin
					outcome_d   = '{ctap_pkg::STATUS_REFUSED, ctap_pkg::ERR_SEQUENCE,
					                hdr_chan_q, 7'd0, 16'd0};
					accepting_d = 1'b0;
				end else if (open_chan_q != hdr_chan_q) begin
					outcome_d   = '{ctap_pkg::STATUS_REFUSED, ctap_pkg::ERR_BUSY,
					                hdr_chan_q, 7'd0, 16'd0};
					accepting_d = 1'b0;
				end else if ({1'b0, report.report_byte[6:0]} != next_seq_q) begin
					outcome_d   = '{ctap_pkg::STATUS_REFUSED, ctap_pkg::ERR_SEQUENCE,
					                hdr_chan_q, 7'd0, 16'd0};
					accepting_d = 1'b0;
				end else begin
					next_seq_d  = next_seq_q + 8'd1;
					accepting_d = 1'b1;
				end
			end
		end else if (pos == ctap_pkg::POS_LEN_HI) begin
			hdr_len_hi_d = report.report_byte;
		end else if (pos == ctap_pkg::POS_LEN_LO && hdr_type_q[ctap_pkg::INIT_FLAG_BIT]) begin
			// init checks: busy before length
			if (open_cmd_q != '0 && open_chan_q != hdr_chan_q) begin
				outcome_d   = '{ctap_pkg::STATUS_REFUSED, ctap_pkg::ERR_BUSY,
				                hdr_chan_q, 7'd0, 16'd0};
				accepting_d = 1'b0;
			end else if (init_len > max_payload_q) begin
				outcome_d   = '{ctap_pkg::STATUS_REFUSED, ctap_pkg::ERR_LENGTH,
				                hdr_chan_q, 7'd0, 16'd0};
				accepting_d = 1'b0;
			end else begin
				open_chan_d = hdr_chan_q;
				open_cmd_d  = hdr_type_q[6:0];
				exp_len_d   = init_len;
				rcv_cnt_d   = '0;
				next_seq_d  = '0;
				accepting_d = 1'b1;
				// zero-length message completes right away
				do_complete = (init_len == '0);
			end
		end

		// payload byte, clamped to the announced length
		data_start = hdr_type_d[ctap_pkg::INIT_FLAG_BIT] ? ctap_pkg::POS_INIT_DATA
		                                                  : ctap_pkg::POS_CONT_DATA;
		if (pos >= data_start && accepting_d && rcv_cnt_d < exp_len_d) begin
			have_pay               = 1'b1;
			pay_res.kind           = ctap_pkg::KIND_PAYLOAD;
			pay_res.payload_byte   = report.report_byte;
			pay_res.payload_offset = rcv_cnt_d;
			rcv_cnt_d              = rcv_cnt_d + 16'd1;
			if (rcv_cnt_d >= exp_len_d)
				do_complete = 1'b1;
		end

		// deliver and close the transaction
		if (do_complete) begin
			outcome_d   = '{ctap_pkg::STATUS_COMPLETE, ctap_pkg::ERR_NONE,
			                open_chan_d, open_cmd_d, exp_len_d};
			accepting_d = 1'b0;
			open_chan_d = '0;
			open_cmd_d  = '0;
			exp_len_d   = '0;
			rcv_cnt_d   = '0;
			next_seq_d  = '0;
		end

		// end-of-packet status, position wraps
		if (pos == ctap_pkg::POS_LAST) begin
			have_stat               = 1'b1;
			stat_res.kind           = ctap_pkg::KIND_STATUS;
			stat_res.packet_status  = outcome_d.status;
			stat_res.error_code     = outcome_d.error;
			stat_res.channel_id     = outcome_d.channel;
			stat_res.command        = outcome_d.command;
			stat_res.message_length = outcome_d.length;
			pos_d                   = '0;
		end else begin
			pos_d = pos + ctap_pkg::POS_W'(1);
		end
	end

	// order results and mark the last one of this word
	always_comb begin
		res0 = have_pay ? pay_res : stat_res;
		res1 = stat_res;
		res0.last_result = !(have_pay && have_stat);
		res1.last_result = 1'b1;
		n_res = {1'b0, have_pay} + {1'b0, have_stat};
	end

	assign wr_ptr_p1 = wr_ptr_q + ctap_pkg::RESQ_AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= ctap_pkg::MAX_PAYLOAD_RESET;
		end else if (cfg_wr_en) begin
			max_payload_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			hdr_chan_q   <= '0;
			hdr_type_q   <= '0;
			hdr_len_hi_q <= '0;
			accepting_q  <= 1'b0;
			outcome_q    <= '0;
			open_chan_q  <= '0;
			open_cmd_q   <= '0;
			exp_len_q    <= '0;
			rcv_cnt_q    <= '0;
			next_seq_q   <= '0;
		end else if (in_acc) begin
			pos_q        <= pos_d;
			hdr_chan_q   <= hdr_chan_d;
			hdr_type_q   <= hdr_type_d;
			hdr_len_hi_q <= hdr_len_hi_d;
			accepting_q  <= accepting_d;
			outcome_q    <= outcome_d;
			open_chan_q  <= open_chan_d;
			open_cmd_q   <= open_cmd_d;
			exp_len_q    <= exp_len_d;
			rcv_cnt_q    <= rcv_cnt_d;
			next_seq_q   <= next_seq_d;
		end
	end

	// queue storage, no reset needed on payload
	always_ff @(posedge clk) begin
		if (in_acc && n_res != 2'd0) begin
			resq_q[wr_ptr_q] <= res0;
		end
		if (in_acc && n_res == 2'd2) begin
			resq_q[wr_ptr_p1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (in_acc)
				wr_ptr_q <= wr_ptr_q + ctap_pkg::RESQ_AW'(n_res);
			if (out_acc)
				rd_ptr_q <= rd_ptr_q + ctap_pkg::RESQ_AW'(1);
			cnt_q <= cnt_q + (in_acc ? ctap_pkg::RESQ_CW'(n_res) : '0)
			               - (out_acc ? ctap_pkg::RESQ_CW'(1) : '0);
		end
	end

	// room for two results
	assign report.ready = (cnt_q <= ctap_pkg::RESQ_CW'(ctap_pkg::RESQ_DEPTH - 2));

	assign result.valid          = (cnt_q != '0);
	assign result.result_kind    = resq_q[rd_ptr_q].kind;
	assign result.payload_byte   = resq_q[rd_ptr_q].payload_byte;
	assign result.payload_offset = resq_q[rd_ptr_q].payload_offset;
	assign result.packet_status  = resq_q[rd_ptr_q].packet_status;
	assign result.error_code     = resq_q[rd_ptr_q].error_code;
	assign result.channel_id     = resq_q[rd_ptr_q].channel_id;
	assign result.command        = resq_q[rd_ptr_q].command;
	assign result.message_length = resq_q[rd_ptr_q].message_length;
	assign result.last_result    = resq_q[rd_ptr_q].last_result;

	// queue never overfills
	a_resq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ctap_pkg::RESQ_CW'(ctap_pkg::RESQ_DEPTH))
		else $error("result queue overfilled");

	// received count stays within the announced length
	a_rcv_within_len: assert property (@(posedge clk) disable iff (!arst_n)
		rcv_cnt_q <= exp_len_q)
		else $error("received count beyond expected length");

	// emitted payload offset lies inside the message
	a_offset_in_msg: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && have_pay) |-> (pay_res.payload_offset < exp_len_q ||
		                          pay_res.payload_offset < exp_len_d ||
		                          do_complete))
		else $error("payload offset outside message");

	// queue empties only through a handshake
	a_valid_drop: assert property (@(posedge clk) disable iff (!arst_n)
		($past(result.valid) && !result.valid) |-> $past(out_acc))
		else $error("result lost from queue");

	// a status goes out at the last position of a packet, and the position then wraps to zero
	a_status_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && have_stat) |=> (pos_q == '0))
		else $error("position did not wrap after status");

endmodule
